/* rtl/core/eogrr_pkg.sv */
`default_nettype none

package eogrr_pkg;

   // Geometry of the segment store
   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_CHANNELS    = 64;
   localparam int MAX_SAMPLES     = 1024;
   localparam int ALPHA_FRAC_BITS = 16;

   localparam int CH_W   = $clog2(MAX_CHANNELS);
   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int ADDR_W = CH_W + IDX_W;
   localparam int CNT_W  = IDX_W + 1;   // holds MAX_SAMPLES itself
   localparam int CHC_W  = CH_W + 1;    // holds MAX_CHANNELS itself
   localparam int THR_W  = 16;

   // Arithmetic widths
   localparam int ALPHA_W = ALPHA_FRAC_BITS + 8;           // Q8.F
   localparam int ACC_W   = 2 * SAMPLE_BITS + IDX_W + 1;   // signed sums of products
   localparam int MUL_A_W = ALPHA_W + 1;
   localparam int MUL_B_W = SAMPLE_BITS + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_CHAN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS  = 2'd3;

   localparam logic [CH_W-1:0]  RST_REF_CHAN = '0;
   localparam logic [THR_W-1:0] RST_THRESHOLD = 16'd100;
   localparam logic [CNT_W-1:0] RST_SAMPLES  = CNT_W'(MAX_SAMPLES);
   localparam logic [CHC_W-1:0] RST_CHANNELS = CHC_W'(MAX_CHANNELS);

   // Item codes
   localparam logic [1:0] MODE_WRITE   = 2'd0;
   localparam logic [1:0] MODE_PROCESS = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic [1:0]                    mode;
      logic [CH_W-1:0]               channel;
      logic [IDX_W-1:0]              sample_index;
      logic signed [SAMPLE_BITS-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic                          result_kind;
      logic                          artifact_found;
      logic signed [SAMPLE_BITS-1:0] sample_out;
   } rsp_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_op_type;

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [ACC_W-2:0] mag;
      logic [ACC_W-2:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [ALPHA_W-1:0] alpha;
   } div_rsp_type;

endpackage

`default_nettype wire

/* rtl/core/eog_regression_removal_top.sv */
// EOG regression artifact removal over a channel-by-sample segment store.
// req_* channel (valid/ready) carries one item: write a sample, process the
// segment, or read a sample back. rsp_* channel returns one beat for process
// (status, artifact flag) and read (stored sample, last artifact flag); a
// write returns nothing. csr_* is a write-only register port, always ready.
// A write is written into the store on acceptance; a read passes through
// S_RD_ADDR and S_RD_DATA before its registered response. If the reference
// channel lies inside the channel count, a process item scans it sample by
// sample (memory read, shared multiplier, accumulate), then runs the
// threshold test; for an artifact, each other channel takes a channel step,
// a dot product, the bit-serial divider and the correction writes. Otherwise
// the item goes straight to its response with no artifact.
// One item is in flight at a time; req_ready is low while it is at work
// and while an undelivered response would block the next one.
// Reset clears the control state, the registers and the artifact flag; the
// sample store itself is undefined until written.
// A stalled receiver holds rsp_data steady and keeps the block from taking
// a new item until the response beat is taken.
`default_nettype none

module eog_regression_removal_top
   import eogrr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // sequencer states
   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
   localparam logic [ST_W-1:0] S_RD_ADDR  = 5'd1;
   localparam logic [ST_W-1:0] S_RD_DATA  = 5'd2;
   localparam logic [ST_W-1:0] S_SC_RD    = 5'd3;
   localparam logic [ST_W-1:0] S_SC_DAT   = 5'd4;
   localparam logic [ST_W-1:0] S_SC_ACC   = 5'd5;
   localparam logic [ST_W-1:0] S_TST_THR  = 5'd6;
   localparam logic [ST_W-1:0] S_TST_MAX  = 5'd7;
   localparam logic [ST_W-1:0] S_TST_MIN  = 5'd8;
   localparam logic [ST_W-1:0] S_TST_EVAL = 5'd9;
   localparam logic [ST_W-1:0] S_CH_NEXT  = 5'd10;
   localparam logic [ST_W-1:0] S_DOT_RD   = 5'd11;
   localparam logic [ST_W-1:0] S_DOT_DAT  = 5'd12;
   localparam logic [ST_W-1:0] S_DOT_ACC  = 5'd13;
   localparam logic [ST_W-1:0] S_DIV_GO   = 5'd14;
   localparam logic [ST_W-1:0] S_DIV_WAIT = 5'd15;
   localparam logic [ST_W-1:0] S_COR_RD   = 5'd16;
   localparam logic [ST_W-1:0] S_COR_DAT  = 5'd17;
   localparam logic [ST_W-1:0] S_COR_WR   = 5'd18;
   localparam logic [ST_W-1:0] S_DONE     = 5'd19;

   localparam int COR_W = MUL_P_W - ALPHA_FRAC_BITS + 2;

   logic [ST_W-1:0]               state_ff, state_in;
   logic [CH_W-1:0]               ref_chan_ff, ref_chan_in;
   logic [THR_W-1:0]              thresh_ff, thresh_in;
   logic [CNT_W-1:0]              samples_ff, samples_in;
   logic [CHC_W-1:0]              channels_ff, channels_in;
   logic [CNT_W-1:0]              n_ff, n_in;
   logic [CHC_W-1:0]              nc_ff, nc_in;
   logic [ADDR_W-1:0]             rq_addr_ff, rq_addr_in;
   logic [CNT_W-1:0]              s_ff, s_in;
   logic [CHC_W-1:0]              c_ff, c_in;
   logic signed [ACC_W-1:0]       sum_ff, sum_in;
   logic signed [ACC_W-1:0]       energy_ff, energy_in;
   logic signed [ACC_W-1:0]       dot_ff, dot_in;
   logic signed [ACC_W-1:0]       nthr_ff, nthr_in;
   logic signed [ACC_W-1:0]       nmax_ff, nmax_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic                          last_art_ff, last_art_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic                          req_fire;
   logic                          s_last;
   logic [CNT_W-1:0]              n_eff;
   logic [CHC_W-1:0]              nc_eff;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic signed [SAMPLE_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]             rd_addr_a;
   logic [ADDR_W-1:0]             rd_addr_b;
   logic signed [SAMPLE_BITS-1:0] rd_data_a;
   logic signed [SAMPLE_BITS-1:0] rd_data_b;

   mul_op_type                    mul_op;
   logic signed [MUL_P_W-1:0]     mul_p;
   logic signed [ACC_W-1:0]       prod_ext;

   div_req_type                   div_req;
   div_rsp_type                   div_rsp;
   logic [ACC_W-1:0]              dot_abs;

   logic signed [ACC_W-1:0]       d_hi;
   logic signed [ACC_W-1:0]       d_lo;
   logic                          artifact;

   logic                          p_neg;
   logic [MUL_P_W-1:0]            p_mag;
   logic [MUL_P_W:0]              p_rnd;
   logic signed [COR_W-1:0]       sc;
   logic signed [COR_W-1:0]       diff;
   logic signed [SAMPLE_BITS-1:0] x_new;

   eogrr_store u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   eogrr_mul u_mul (
      .clock  (clock),
      .mul_op (mul_op),
      .mul_p  (mul_p)
   );

   eogrr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // handshakes
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign s_last   = (s_ff == (n_ff - CNT_W'(1)));
   assign prod_ext = ACC_W'(mul_p);

   // clamp segment length and channel count
   always_comb begin
      if (samples_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (samples_ff > CNT_W'(MAX_SAMPLES)) begin
         n_eff = CNT_W'(MAX_SAMPLES);
      end else begin
         n_eff = samples_ff;
      end
      if (channels_ff == '0) begin
         nc_eff = CHC_W'(1);
      end else if (channels_ff > CHC_W'(MAX_CHANNELS)) begin
         nc_eff = CHC_W'(MAX_CHANNELS);
      end else begin
         nc_eff = channels_ff;
      end
   end

   // store addressing: port b always follows the reference channel
   assign rd_addr_a = (state_ff == S_RD_ADDR) ? rq_addr_ff
                                              : {c_ff[CH_W-1:0], s_ff[IDX_W-1:0]};
   assign rd_addr_b = {ref_chan_ff, s_ff[IDX_W-1:0]};

   assign wr_en   = (req_fire && req_data.mode == MODE_WRITE) || (state_ff == S_COR_WR);
   assign wr_addr = (state_ff == S_COR_WR) ? {c_ff[CH_W-1:0], s_ff[IDX_W-1:0]}
                                           : {req_data.channel, req_data.sample_index};
   assign wr_data = (state_ff == S_COR_WR) ? x_new : req_data.sample_in;

   // multiplier operand select
   always_comb begin
      mul_op.a = '0;
      mul_op.b = '0;
      unique case (state_ff)
         S_SC_DAT: begin
            mul_op.a = MUL_A_W'(rd_data_b);
            mul_op.b = MUL_B_W'(rd_data_b);
         end
         S_TST_THR: begin
            mul_op.a = MUL_A_W'($signed({1'b0, n_ff}));
            mul_op.b = $signed({1'b0, thresh_ff});
         end
         S_TST_MAX: begin
            mul_op.a = MUL_A_W'($signed({1'b0, n_ff}));
            mul_op.b = MUL_B_W'(max_ff);
         end
         S_TST_MIN: begin
            mul_op.a = MUL_A_W'($signed({1'b0, n_ff}));
            mul_op.b = MUL_B_W'(min_ff);
         end
         S_DOT_DAT: begin
            mul_op.a = MUL_A_W'(rd_data_a);
            mul_op.b = MUL_B_W'(rd_data_b);
         end
         S_COR_DAT: begin
            mul_op.a = MUL_A_W'(div_rsp.alpha);
            mul_op.b = MUL_B_W'(rd_data_b);
         end
         default: begin
            mul_op.a = '0;
            mul_op.b = '0;
         end
      endcase
   end

   // divider request
   always_comb begin
      dot_abs         = dot_ff[ACC_W-1] ? -dot_ff : dot_ff;
      div_req.start   = (state_ff == S_DIV_GO);
      div_req.neg     = dot_ff[ACC_W-1];
      div_req.mag     = dot_abs[ACC_W-2:0];
      div_req.divisor = energy_ff[ACC_W-2:0];
   end

   // threshold test: N*max - sum > N*thr or N*min - sum < -N*thr
   always_comb begin
      d_hi     = nmax_ff - sum_ff - nthr_ff;
      d_lo     = prod_ext - sum_ff + nthr_ff;
      artifact = (d_hi > 0) || (d_lo < 0);
   end

   // correction: x - round(alpha*ref / 2^F), saturated
   always_comb begin
      p_neg = mul_p[MUL_P_W-1];
      p_mag = p_neg ? MUL_P_W'(-mul_p) : MUL_P_W'(mul_p);
      p_rnd = {1'b0, p_mag} + ((MUL_P_W+1)'(1) << (ALPHA_FRAC_BITS - 1));
      sc    = $signed({1'b0, p_rnd[MUL_P_W:ALPHA_FRAC_BITS]});
      if (p_neg) begin
         sc = -sc;
      end
      diff = COR_W'(rd_data_a) - sc;
      if (!diff[COR_W-1] && (diff[COR_W-2:SAMPLE_BITS-1] != '0)) begin
         x_new = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (diff[COR_W-1] && (diff[COR_W-2:SAMPLE_BITS-1] != '1)) begin
         x_new = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         x_new = diff[SAMPLE_BITS-1:0];
      end
   end

   // configuration registers
   always_comb begin
      ref_chan_in = ref_chan_ff;
      thresh_in   = thresh_ff;
      samples_in  = samples_ff;
      channels_in = channels_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REF_CHAN:  ref_chan_in = csr_data[CH_W-1:0];
            CSR_THRESHOLD: thresh_in   = csr_data[THR_W-1:0];
            CSR_SAMPLES:   samples_in  = csr_data[CNT_W-1:0];
            CSR_CHANNELS:  channels_in = csr_data[CHC_W-1:0];
            default:       ref_chan_in = ref_chan_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      nc_in        = nc_ff;
      rq_addr_in   = rq_addr_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      sum_in       = sum_ff;
      energy_in    = energy_ff;
      dot_in       = dot_ff;
      nthr_in      = nthr_ff;
      nmax_in      = nmax_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      last_art_in  = last_art_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rq_addr_in = {req_data.channel, req_data.sample_index};
               n_in       = n_eff;
               nc_in      = nc_eff;
               s_in       = '0;
               sum_in     = '0;
               energy_in  = '0;
               priority case (req_data.mode)
                  MODE_READ: state_in = S_RD_ADDR;
                  MODE_PROCESS: begin
                     if ({1'b0, ref_chan_ff} >= nc_eff) begin
                        last_art_in = 1'b0;
                        state_in    = S_DONE;
                     end else begin
                        state_in = S_SC_RD;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RD_ADDR: state_in = S_RD_DATA;
         S_RD_DATA: begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.result_kind    = KIND_READ;
            rsp_data_in.artifact_found = last_art_ff;
            rsp_data_in.sample_out     = rd_data_a;
            state_in                   = S_IDLE;
         end
         S_SC_RD:  state_in = S_SC_DAT;
         S_SC_DAT: state_in = S_SC_ACC;
         S_SC_ACC: begin
            sum_in    = sum_ff + ACC_W'(rd_data_b);
            energy_in = energy_ff + prod_ext;
            if (s_ff == '0 || rd_data_b > max_ff) begin
               max_in = rd_data_b;
            end
            if (s_ff == '0 || rd_data_b < min_ff) begin
               min_in = rd_data_b;
            end
            s_in     = s_ff + CNT_W'(1);
            state_in = s_last ? S_TST_THR : S_SC_RD;
         end
         S_TST_THR: state_in = S_TST_MAX;
         S_TST_MAX: begin
            nthr_in  = prod_ext;
            state_in = S_TST_MIN;
         end
         S_TST_MIN: begin
            nmax_in  = prod_ext;
            state_in = S_TST_EVAL;
         end
         S_TST_EVAL: begin
            if (artifact && energy_ff != '0) begin
               c_in     = '0;
               state_in = S_CH_NEXT;
            end else begin
               last_art_in = 1'b0;
               state_in    = S_DONE;
            end
         end
         S_CH_NEXT: begin
            if (c_ff == nc_ff) begin
               last_art_in = 1'b1;
               state_in    = S_DONE;
            end else if (c_ff[CH_W-1:0] == ref_chan_ff) begin
               c_in = c_ff + CHC_W'(1);
            end else begin
               s_in     = '0;
               dot_in   = '0;
               state_in = S_DOT_RD;
            end
         end
         S_DOT_RD:  state_in = S_DOT_DAT;
         S_DOT_DAT: state_in = S_DOT_ACC;
         S_DOT_ACC: begin
            dot_in   = dot_ff + prod_ext;
            s_in     = s_ff + CNT_W'(1);
            state_in = s_last ? S_DIV_GO : S_DOT_RD;
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               s_in     = '0;
               state_in = S_COR_RD;
            end
         end
         S_COR_RD:  state_in = S_COR_DAT;
         S_COR_DAT: state_in = S_COR_WR;
         S_COR_WR: begin
            s_in = s_ff + CNT_W'(1);
            if (s_last) begin
               c_in     = c_ff + CHC_W'(1);
               state_in = S_CH_NEXT;
            end else begin
               state_in = S_COR_RD;
            end
         end
         S_DONE: begin
            rsp_valid_in               = 1'b1;
            rsp_data_in.result_kind    = KIND_STATUS;
            rsp_data_in.artifact_found = last_art_ff;
            rsp_data_in.sample_out     = '0;
            state_in                   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ref_chan_ff  <= RST_REF_CHAN;
         thresh_ff    <= RST_THRESHOLD;
         samples_ff   <= RST_SAMPLES;
         channels_ff  <= RST_CHANNELS;
         last_art_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_chan_ff  <= ref_chan_in;
         thresh_ff    <= thresh_in;
         samples_ff   <= samples_in;
         channels_ff  <= channels_in;
         last_art_ff  <= last_art_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      nc_ff       <= nc_in;
      rq_addr_ff  <= rq_addr_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      sum_ff      <= sum_in;
      energy_ff   <= energy_in;
      dot_ff      <= dot_in;
      nthr_ff     <= nthr_in;
      nmax_ff     <= nmax_in;
      max_ff      <= max_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a response beat only starts from the two answering states
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE || $past(state_ff) == S_RD_DATA))
      else $error("response beat raised outside an answering state");

   // the divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_WAIT))
      else $error("divider result arrived while not waiting");

   // corrections never touch the reference or channels past the count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COR_WR) |-> (c_ff[CH_W-1:0] != ref_chan_ff && c_ff < nc_ff))
      else $error("correction write to an illegal channel");

   // sample counter stays inside the segment while scanning
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SC_ACC || state_ff == S_DOT_ACC || state_ff == S_COR_WR)
         |-> (s_ff < n_ff))
      else $error("sample counter ran past the segment");

endmodule

`default_nettype wire

/* rtl/core/eogrr_store.sv */
`default_nettype none

module eogrr_store
   import eogrr_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ADDR_W-1:0]             wr_addr,
   input  wire logic signed [SAMPLE_BITS-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]             rd_addr_a,
   input  wire logic [ADDR_W-1:0]             rd_addr_b,
   output logic signed [SAMPLE_BITS-1:0]      rd_data_a,
   output logic signed [SAMPLE_BITS-1:0]      rd_data_b
);

   logic signed [SAMPLE_BITS-1:0] store_mem [2**ADDR_W];
   logic signed [SAMPLE_BITS-1:0] rd_data_a_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_b_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      rd_data_a_ff <= store_mem[rd_addr_a];
      rd_data_b_ff <= store_mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

/* rtl/core/eogrr_mul.sv */
`default_nettype none

module eogrr_mul
   import eogrr_pkg::*;
(
   input  wire logic                      clock,
   input  wire mul_op_type                mul_op,
   output logic signed [MUL_P_W-1:0]      mul_p
);

   logic signed [MUL_P_W-1:0] prod_ff;

   // shared signed multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= $signed(mul_op.a) * $signed(mul_op.b);
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

/* rtl/core/eogrr_div.sv */
`default_nettype none

module eogrr_div
   import eogrr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int MAG_W  = ACC_W - 1;
   localparam int DVD_W  = MAG_W + ALPHA_FRAC_BITS + 1;   // one extra bit for rounding
   localparam int REM_W  = MAG_W + 1;
   localparam int Q_W    = ALPHA_W + 1;
   localparam int STEP_W = $clog2(DVD_W + 1);
   localparam int INT_W  = 7;                             // integer part saturates at 2^7
   localparam logic [Q_W-1:0] MAG_HI = Q_W'((64'd1 << (ALPHA_W - 1)) - 64'd1);
   localparam logic signed [ALPHA_W-1:0] ALPHA_MAX = {1'b0, {(ALPHA_W-1){1'b1}}};
   localparam logic signed [ALPHA_W-1:0] ALPHA_MIN = {1'b1, {(ALPHA_W-1){1'b0}}};

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic              sat_ff, sat_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  dvs_ff, dvs_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [REM_W-1:0]  r_sh;
   logic [REM_W-1:0]  r_sub;
   logic              ge;
   logic [Q_W:0]      q_inc;
   logic [Q_W-1:0]    mag_r;

   // one restoring step per cycle
   always_comb begin
      r_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      r_sub = r_sh - {1'b0, dvs_ff};
      ge    = (r_sh >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      step_in = step_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.neg;
         sat_in  = ({{INT_W{1'b0}}, div_req.mag} >= {div_req.divisor, {INT_W{1'b0}}});
         dvd_in  = {div_req.mag, {(ALPHA_FRAC_BITS+1){1'b0}}};
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         q_in    = '0;
         step_in = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in  = ge ? r_sub[MAG_W-1:0] : r_sh[MAG_W-1:0];
         q_in    = {q_ff[Q_W-2:0], ge};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   // round half away from zero on the magnitude, then saturate to Q8.F
   always_comb begin
      q_inc = {1'b0, q_ff} + (Q_W+1)'(1);
      mag_r = q_inc[Q_W:1];
      div_rsp.done = done_ff;
      if (neg_ff) begin
         div_rsp.alpha = sat_ff ? ALPHA_MIN : -$signed(mag_r[ALPHA_W-1:0]);
      end else begin
         div_rsp.alpha = (sat_ff || mag_r > MAG_HI) ? ALPHA_MAX
                                                    : $signed(mag_r[ALPHA_W-1:0]);
      end
   end

endmodule

`default_nettype wire
